// ----- hw/rtl/xeu_pkg.sv -----
// shared constants, entity tables and types for the xml entity unescaper
package xeu_pkg;

    // window of held bytes and the largest burst of results per input beat
    localparam int C_WIN_DEPTH = 5;
    localparam int C_NUM_ENT   = 5;
    localparam int C_ENT_MAX   = 6;
    localparam int C_BURST_MAX = C_WIN_DEPTH + 1;
    localparam int C_CNT_W     = $clog2(C_BURST_MAX + 1);

    localparam logic [7:0] C_AMP = 8'h26;
    localparam logic [7:0] C_NUL = 8'h00;

    // entity spellings, zero padded
    localparam logic [7:0] C_ENT_TEXT [C_NUM_ENT][C_ENT_MAX] = '{
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}   // &quot;
    };

    localparam logic [C_CNT_W-1:0] C_ENT_LEN [C_NUM_ENT] = '{
        C_CNT_W'(4), C_CNT_W'(4), C_CNT_W'(5), C_CNT_W'(6), C_CNT_W'(6)
    };

    localparam logic [7:0] C_ENT_CHAR [C_NUM_ENT] = '{
        8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22
    };

    // results of one input beat: n bytes, last marks end of string
    typedef struct packed {
        logic [C_BURST_MAX-1:0][7:0] data;
        logic [C_CNT_W-1:0]          n;
        logic                        last;
    } t_burst;

endpackage

// ----- hw/rtl/xeu_decode.sv -----
// entity window state and single-pass decode of one input byte
module xeu_decode
    import xeu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  logic   [7:0] i_byte,
    input  logic   i_last,
    output t_burst o_burst,
    output logic   o_load
);

    logic [7:0]         r_win [C_WIN_DEPTH];
    logic [7:0]         n_win [C_WIN_DEPTH];
    logic [C_CNT_W-1:0] r_cnt, n_cnt;
    logic               r_term, n_term;

    logic [C_CNT_W-1:0] flush_k;
    logic               put_x;
    logic [7:0]         x_byte;
    logic               full_hit;
    logic [7:0]         full_char;
    logic               prefix;
    logic               ok;

    // compare the held window plus the new byte against every entity
    always_comb begin
        full_hit  = 1'b0;
        full_char = C_NUL;
        prefix    = 1'b0;
        ok        = 1'b0;
        for (int e = 0; e < C_NUM_ENT; e++) begin
            ok = (r_cnt < C_ENT_LEN[e]) && (r_cnt < C_CNT_W'(C_ENT_MAX));
            for (int i = 0; i < C_WIN_DEPTH; i++) begin
                if ((C_CNT_W'(i) < r_cnt) && (r_win[i] != C_ENT_TEXT[e][i])) begin
                    ok = 1'b0;
                end
            end
            for (int j = 0; j < C_ENT_MAX; j++) begin
                if ((C_CNT_W'(j) == r_cnt) && (C_ENT_TEXT[e][j] != i_byte)) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                if (r_cnt + C_CNT_W'(1) == C_ENT_LEN[e]) begin
                    full_hit  = 1'b1;
                    full_char = C_ENT_CHAR[e];
                end else begin
                    prefix = 1'b1;
                end
            end
        end
    end

    // next state and the burst of results for this beat
    always_comb begin
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_term  = r_term;
        flush_k = '0;
        put_x   = 1'b0;
        x_byte  = i_byte;
        if (r_term) begin
            n_term = !i_last;
            n_cnt  = '0;
        end else if (i_byte == C_NUL) begin
            flush_k = r_cnt;
            n_cnt   = '0;
            n_term  = !i_last;
        end else if ((r_cnt != '0) && full_hit) begin
            x_byte = full_char;
            put_x  = 1'b1;
            n_cnt  = '0;
        end else if ((r_cnt != '0) && prefix && (r_cnt < C_CNT_W'(C_WIN_DEPTH))) begin
            for (int i = 0; i < C_WIN_DEPTH; i++) begin
                if (C_CNT_W'(i) == r_cnt) begin
                    n_win[i] = i_byte;
                end
            end
            n_cnt = r_cnt + C_CNT_W'(1);
            // string ends inside a partial entity: all of it goes out literally
            if (i_last) begin
                flush_k = r_cnt;
                put_x   = 1'b1;
                n_cnt   = '0;
            end
        end else begin
            flush_k = r_cnt;
            if ((i_byte == C_AMP) && !i_last) begin
                n_win[0] = i_byte;
                n_cnt    = C_CNT_W'(1);
            end else begin
                put_x = 1'b1;
                n_cnt = '0;
            end
        end
    end

    // pack flushed window bytes followed by the optional single byte
    always_comb begin
        for (int i = 0; i < C_WIN_DEPTH; i++) begin
            o_burst.data[i] = (C_CNT_W'(i) < flush_k) ? r_win[i] : x_byte;
        end
        o_burst.data[C_BURST_MAX-1] = x_byte;
        o_burst.n    = flush_k + C_CNT_W'(put_x);
        o_burst.last = i_last;
        o_load       = i_accept && ((o_burst.n != '0) || i_last);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_term <= 1'b0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_term <= n_term;
        end
    end

    // held window bytes
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ----- hw/rtl/xeu_emit.sv -----
// result register that sends a burst out one beat per cycle while the output is ready
module xeu_emit
    import xeu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_has,
    output logic       o_last
);

    t_burst             r_burst;
    logic               r_valid;
    logic [C_CNT_W-1:0] r_idx;
    logic [C_CNT_W-1:0] last_idx;
    logic               at_end;

    // position of the final beat; a bare end marker is one beat
    always_comb begin
        last_idx = (r_burst.n == '0) ? '0 : r_burst.n - C_CNT_W'(1);
        at_end   = (r_idx == last_idx);
        o_valid  = r_valid;
        o_has    = (r_burst.n != '0);
        o_byte   = o_has ? r_burst.data[r_idx] : C_NUL;
        o_last   = r_burst.last && at_end;
        o_free   = !r_valid || (i_ready && at_end);
    end

    // beat position and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            if (at_end) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + C_CNT_W'(1);
            end
        end
    end

    // burst payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule

// ----- hw/rtl/xml_entity_unescape_top.sv -----
// Streaming decoder of the five predefined xml entities, one byte per beat.
// The first result of a byte is registered and shown in the cycle after it is accepted.
// Throughput: one byte per cycle while the output is ready and each byte gives at most
// one result; a byte with n results (up to six) stalls the input until all are sent.
// Reset: synchronous active low; clears window count, end-of-string state and output.
module xml_entity_unescape_top
    import xeu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] has_byte
    output logic       m_axis_tlast
);

    t_burst burst;
    logic   load;
    logic   accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    // window state and decode
    xeu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_burst  (burst),
        .o_load   (load)
    );

    // result register and serializer
    xeu_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .o_free  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_has   (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

`ifndef SYNTH
    // input stalls only behind a pending burst
    a_stall_needs_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // a bare end marker always closes the string
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("bare marker without last flag");

    // the last byte of a string always yields a result
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> m_axis_tvalid)
        else $error("last input beat produced no result");

    // a bare marker never carries a byte value
    a_bare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == C_NUL))
        else $error("bare marker with nonzero data");
`endif

endmodule
